// File: rtl/greedy_box_suppression_defines.svh
// ----------------------------------------------------------------------------
// greedy box suppression assertion macros
// concurrent assertion wrappers used by the checker file
// ----------------------------------------------------------------------------
`ifndef GREEDY_BOX_SUPPRESSION_DEFINES_SVH
`define GREEDY_BOX_SUPPRESSION_DEFINES_SVH

// checked only outside reset
`define GBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define GBS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// shared constants and types of the greedy box suppression block
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int MAX_BOXES   = 1024;
  localparam int IDX_W       = $clog2(MAX_BOXES);
  localparam int SP_W        = $clog2(MAX_BOXES + 1);
  localparam int BOX_INDEX_W = 10;
  localparam int COORD_W     = 17;
  localparam int AREA_W      = 30;
  localparam int THR_W       = 16;
  localparam int QDEPTH      = 2;
  localparam int Q_PTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int Q_CNT_W     = $clog2(QDEPTH + 1);

  localparam logic [THR_W-1:0] THR_RESET = 16'h8000;

  typedef struct packed {
    logic                      first;
    logic                      ovf;
    logic [BOX_INDEX_W-1:0]    pos;
    logic signed [COORD_W-1:0] l;
    logic signed [COORD_W-1:0] t;
    logic signed [COORD_W-1:0] r;
    logic signed [COORD_W-1:0] b;
    logic [AREA_W-1:0]         area;
  } gbs_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] l;
    logic signed [COORD_W-1:0] t;
    logic signed [COORD_W-1:0] r;
    logic signed [COORD_W-1:0] b;
    logic [AREA_W-1:0]         area;
  } gbs_kept_t;

  typedef struct packed {
    logic full;
    logic empty;
  } gbs_q_stat_t;

endpackage

// File: rtl/gbs_front.sv
// ----------------------------------------------------------------------------
// gbs_front
// accepts boxes, tracks the set position and builds queue entries
// ----------------------------------------------------------------------------
module gbs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_box_left,
  input  logic signed [15:0] in_box_top,
  input  logic        [14:0] in_box_width,
  input  logic        [14:0] in_box_height,
  input  logic               in_first_of_set,
  input  gbs_pkg::gbs_q_stat_t q_stat,
  output logic               q_push,
  output gbs_pkg::gbs_item_t q_item
);
  import gbs_pkg::*;

  logic [SP_W-1:0] set_pos_r;
  logic [SP_W-1:0] set_pos_nxt;
  logic [SP_W-1:0] sp;
  logic            ovf;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !in_stall;

  always_comb begin
    sp  = in_first_of_set ? '0 : set_pos_r;
    ovf = (sp >= SP_W'(MAX_BOXES));
    q_item.first = in_first_of_set;
    q_item.ovf   = ovf;
    q_item.pos   = ovf ? '0 : BOX_INDEX_W'(sp);
    q_item.l     = {in_box_left[15], in_box_left};
    q_item.t     = {in_box_top[15], in_box_top};
    q_item.r     = {in_box_left[15], in_box_left} + {2'b00, in_box_width};
    q_item.b     = {in_box_top[15], in_box_top} + {2'b00, in_box_height};
    q_item.area  = AREA_W'(in_box_width) * AREA_W'(in_box_height);
    set_pos_nxt  = set_pos_r;
    if (q_push) begin
      set_pos_nxt = ovf ? sp : sp + SP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_pos_r <= '0;
    end else begin
      set_pos_r <= set_pos_nxt;
    end
  end

endmodule

// File: rtl/gbs_queue.sv
// ----------------------------------------------------------------------------
// gbs_queue
// short fifo of classified boxes between front and back
// ----------------------------------------------------------------------------
module gbs_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  gbs_pkg::gbs_item_t   push_item,
  input  logic                 pop,
  output gbs_pkg::gbs_item_t   pop_item,
  output gbs_pkg::gbs_q_stat_t stat
);
  import gbs_pkg::*;

  gbs_item_t          entry_r [QDEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r;
  logic [Q_CNT_W-1:0] cnt_nxt;

  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    return (p == Q_PTR_W'(QDEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
  endfunction

  assign stat.full  = (cnt_r == Q_CNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_item   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: rtl/gbs_back.sv
// ----------------------------------------------------------------------------
// gbs_back
// compares each box that is not an overflow with the kept list and reports the decision
// ----------------------------------------------------------------------------
module gbs_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [15:0]            cfg_wr_data,
  input  gbs_pkg::gbs_q_stat_t   q_stat,
  input  gbs_pkg::gbs_item_t     q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [9:0]             out_box_index,
  output logic                   out_kept,
  output logic                   out_overflow
);
  import gbs_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_OUT} state_t;

  state_t          state_r, state_nxt;
  gbs_item_t       cur_r, cur_nxt;
  logic [SP_W-1:0] cnt_r, cnt_nxt;
  logic [SP_W-1:0] cnt_eff;
  logic [SP_W-1:0] rd_idx_r, rd_idx_nxt;
  logic            supp_r, supp_nxt;
  logic            res_kept_r, res_kept_nxt;
  logic            keep;
  logic            out_valid_r, out_valid_nxt;
  logic [9:0]      out_index_r, out_index_nxt;
  logic            out_kept_r, out_kept_nxt;
  logic            out_ovf_r, out_ovf_nxt;
  logic [THR_W-1:0] thr_r;

  gbs_kept_t       mem [MAX_BOXES];
  gbs_kept_t       rd_data_r;
  gbs_kept_t       wr_word;
  logic            issue;
  logic            wr_en;

  // compare pipeline
  logic                      v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [COORD_W-1:0] rmin, lmax, bmin, tmax;
  logic [COORD_W:0]          iw_r, ih_r;
  logic [AREA_W-1:0]         karea2_r, karea3_r;
  logic [AREA_W-1:0]         inter3_r, inter4_r;
  logic [AREA_W:0]           uni4_r;
  logic [AREA_W+16:0]        lhs5_r, prod5_r;
  logic                      iw_pos, ih_pos;
  logic                      pipe_busy;

  assign out_valid     = out_valid_r;
  assign out_box_index = out_index_r;
  assign out_kept      = out_kept_r;
  assign out_overflow  = out_ovf_r;
  assign pipe_busy     = v1_r | v2_r | v3_r | v4_r | v5_r;
  assign wr_word       = '{l: cur_r.l, t: cur_r.t, r: cur_r.r, b: cur_r.b, area: cur_r.area};

  always_comb begin
    rmin   = (cur_r.r < rd_data_r.r) ? cur_r.r : rd_data_r.r;
    lmax   = (cur_r.l > rd_data_r.l) ? cur_r.l : rd_data_r.l;
    bmin   = (cur_r.b < rd_data_r.b) ? cur_r.b : rd_data_r.b;
    tmax   = (cur_r.t > rd_data_r.t) ? cur_r.t : rd_data_r.t;
    iw_pos = !iw_r[COORD_W] && (iw_r != '0);
    ih_pos = !ih_r[COORD_W] && (ih_r != '0);
  end

  always_ff @(posedge clk) begin
    iw_r     <= {rmin[COORD_W-1], rmin} - {lmax[COORD_W-1], lmax};
    ih_r     <= {bmin[COORD_W-1], bmin} - {tmax[COORD_W-1], tmax};
    karea2_r <= rd_data_r.area;
    inter3_r <= (iw_pos && ih_pos) ? AREA_W'(iw_r[14:0]) * AREA_W'(ih_r[14:0]) : '0;
    karea3_r <= karea2_r;
    uni4_r   <= {1'b0, cur_r.area} + {1'b0, karea3_r} - {1'b0, inter3_r};
    inter4_r <= inter3_r;
    prod5_r  <= (AREA_W+17)'(thr_r) * (AREA_W+17)'(uni4_r);
    lhs5_r   <= {1'b0, inter4_r, 16'h0000};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // kept list
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IDX_W'(cnt_r)] <= wr_word;
    end
    if (issue) begin
      rd_data_r <= mem[IDX_W'(rd_idx_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    cnt_eff       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    supp_nxt      = supp_r;
    res_kept_nxt  = res_kept_r;
    out_valid_nxt = out_valid_r;
    out_index_nxt = out_index_r;
    out_kept_nxt  = out_kept_r;
    out_ovf_nxt   = out_ovf_r;
    q_pop         = 1'b0;
    issue         = 1'b0;
    wr_en         = 1'b0;
    keep          = 1'b0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (v5_r && (lhs5_r > prod5_r)) begin
      supp_nxt = 1'b1;
    end
    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          q_pop      = 1'b1;
          cur_nxt    = q_item;
          cnt_eff    = q_item.first ? '0 : cnt_r;
          cnt_nxt    = cnt_eff;
          supp_nxt   = 1'b0;
          rd_idx_nxt = '0;
          if (q_item.ovf) begin
            res_kept_nxt = 1'b0;
            state_nxt    = S_OUT;
          end else if (cnt_eff == '0) begin
            state_nxt = S_DRAIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        issue      = 1'b1;
        rd_idx_nxt = rd_idx_r + SP_W'(1);
        if (rd_idx_r == cnt_r - SP_W'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!pipe_busy) begin
          keep         = !supp_r && (cnt_r < SP_W'(MAX_BOXES));
          wr_en        = keep;
          res_kept_nxt = keep;
          if (keep) begin
            cnt_nxt = cnt_r + SP_W'(1);
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = cur_r.pos;
          out_kept_nxt  = res_kept_r;
          out_ovf_nxt   = cur_r.ovf;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_idx_r    <= '0;
      supp_r      <= 1'b0;
      res_kept_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_idx_r    <= rd_idx_nxt;
      supp_r      <= supp_nxt;
      res_kept_r  <= res_kept_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r       <= cur_nxt;
    out_index_r <= out_index_nxt;
    out_kept_r  <= out_kept_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

endmodule

// File: rtl/greedy_box_suppression.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression
// greedy non-maximum suppression of score-sorted boxes by overlap ratio
// ----------------------------------------------------------------------------
// boxes enter on the in_ channel (valid/stall), one per transfer, sorted by
// falling score; in_first_of_set starts a new set and empties the kept list.
// each box yields one result on the out_ channel: its index in the set,
// whether it was kept, and an overflow flag once the set holds 1024 boxes.
// cfg_wr_en/cfg_wr_data load the Q0.16 overlap limit (reset 0x8000).
// a box is compared with the k boxes already kept, one per cycle, through a
// compare pipeline on a single kept-list memory read port; the compare side
// starts on a box only once the result of the last box has been handed to
// the out_ registers.
// a two-entry queue takes new boxes while a result waits on out_stall;
// a held result keeps the next result in the compare side until it is taken.
// reset empties the queue, the kept list and the set position, clears
// out_valid and restores the overlap limit; no clearing pass is needed.
// ----------------------------------------------------------------------------
module greedy_box_suppression (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_box_left,
  input  logic signed [15:0] in_box_top,
  input  logic        [14:0] in_box_width,
  input  logic        [14:0] in_box_height,
  input  logic               in_first_of_set,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [9:0]         out_box_index,
  output logic               out_kept,
  output logic               out_overflow
);
  import gbs_pkg::*;

  gbs_q_stat_t q_stat;
  gbs_item_t   push_item;
  gbs_item_t   pop_item;
  logic        q_push;
  logic        q_pop;

  gbs_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_box_left     (in_box_left),
    .in_box_top      (in_box_top),
    .in_box_width    (in_box_width),
    .in_box_height   (in_box_height),
    .in_first_of_set (in_first_of_set),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_item          (push_item)
  );

  gbs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  gbs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .q_stat        (q_stat),
    .q_item        (pop_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_box_index (out_box_index),
    .out_kept      (out_kept),
    .out_overflow  (out_overflow)
  );

endmodule

// File: rtl/gbs_chk.sv
// ----------------------------------------------------------------------------
// gbs_chk
// port-level checks of the greedy box suppression block
// ----------------------------------------------------------------------------
`include "greedy_box_suppression_defines.svh"

module gbs_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [9:0]         out_box_index,
  input logic               out_kept,
  input logic               out_overflow
);

  `GBS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "stalled result dropped")

  `GBS_ASSERT(a_out_stable,
    out_valid && out_stall |=> $stable(out_box_index) && $stable(out_kept) && $stable(out_overflow),
    "stalled result changed")

  `GBS_ASSERT(a_ovf_drop, out_valid && out_overflow |-> !out_kept && out_box_index == 10'd0, "overflow box not dropped")

  `GBS_ASSERT_RST(a_rst_idle, !rst_n |=> !out_valid, "result shown after reset")

  `GBS_ASSERT_RST(a_rst_room, !rst_n |=> !in_stall, "input stalled after reset")

endmodule

bind greedy_box_suppression gbs_chk u_chk (.*);

// File: tb/sv/greedy_box_suppression_tb.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression_tb
// self-checking bench for greedy overlap suppression of score-sorted boxes
// ----------------------------------------------------------------------------
// a scoreboard class keeps its own kept-box list and overlap limit and
// predicts index, kept and overflow for every box transfer. each result
// transfer is checked against the oldest prediction. a directed pass covers
// edge boxes, empty and zero-area overlaps, set restarts and limit extremes.
// random sets of jittered boxes run under four idle/stall mixes with limit
// changes between sets.
// ----------------------------------------------------------------------------
module greedy_box_suppression_tb;

  localparam int CLK_PERIOD   = 8;
  localparam int LIMIT_CYCLES = 3_000_000;

  typedef struct {
    logic [9:0] box_index;
    logic       kept;
    logic       overflow;
  } verdict_t;

  typedef struct {
    logic signed [16:0] l;
    logic signed [16:0] t;
    logic signed [16:0] r;
    logic signed [16:0] b;
    logic [29:0]        area;
  } kept_box_t;

  class suppression_scoreboard;
    kept_box_t   kept_boxes[gbs_pkg::MAX_BOXES];
    int unsigned kept_total;
    int unsigned set_pos;
    logic [15:0] iou_limit;
    verdict_t    expected_verdicts[$];
    int unsigned errors;

    function new();
      kept_total = 0;
      set_pos    = 0;
      iou_limit  = gbs_pkg::THR_RESET;
      errors     = 0;
    endfunction

    function void set_limit(logic [15:0] value);
      iou_limit = value;
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    // greedy overlap test of one accepted box against the kept list
    function void predict_box(logic signed [15:0] left, logic signed [15:0] top,
                              logic [14:0] width, logic [14:0] height, logic first);
      longint lft, tp, rgt, bot, iw, ih, kl, kt, kr, kb;
      longint unsigned area, inter, uni;
      bit survive;
      verdict_t v;
      lft = left;
      tp = top;
      rgt = lft + longint'(width);
      bot = tp + longint'(height);
      area = longint'(width) * longint'(height);
      survive = 1'b1;
      if (first) begin
        kept_total = 0;
        set_pos = 0;
      end
      v.kept = 1'b0;
      if (set_pos >= gbs_pkg::MAX_BOXES) begin
        v.box_index = '0;
        v.overflow = 1'b1;
      end else begin
        v.box_index = set_pos[9:0];
        v.overflow = 1'b0;
        set_pos++;
        for (int j = 0; j < kept_total; j++) begin
          kl = kept_boxes[j].l;
          kt = kept_boxes[j].t;
          kr = kept_boxes[j].r;
          kb = kept_boxes[j].b;
          iw = ((rgt < kr) ? rgt : kr) - ((lft > kl) ? lft : kl);
          ih = ((bot < kb) ? bot : kb) - ((tp > kt) ? tp : kt);
          // empty intersection counts as zero
          if (iw > 0 && ih > 0) inter = iw * ih;
          else inter = 0;
          uni = area + kept_boxes[j].area - inter;
          if (inter * 64'd65536 > longint'(iou_limit) * uni) survive = 1'b0;
        end
        if (survive && kept_total < gbs_pkg::MAX_BOXES) begin
          kept_boxes[kept_total].l = lft[16:0];
          kept_boxes[kept_total].t = tp[16:0];
          kept_boxes[kept_total].r = rgt[16:0];
          kept_boxes[kept_total].b = bot[16:0];
          kept_boxes[kept_total].area = area[29:0];
          kept_total++;
          v.kept = 1'b1;
        end
      end
      expected_verdicts.insert(expected_verdicts.size(), v);
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_verdict(logic [9:0] index, logic kept, logic overflow);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer: expected none, actual index %0d",
                 $time, index);
        return;
      end
      want = expected_verdicts.pop_front();
      if (index !== want.box_index) report("box_index", want.box_index, index);
      if (kept !== want.kept) report("kept", want.kept, kept);
      if (overflow !== want.overflow) report("overflow", want.overflow, overflow);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [15:0]        cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_box_left = '0;
  logic signed [15:0] in_box_top = '0;
  logic [14:0]        in_box_width = '0;
  logic [14:0]        in_box_height = '0;
  logic               in_first_of_set = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [9:0]         out_box_index;
  logic               out_kept;
  logic               out_overflow;

  int send_idle_pct = 0;
  int stall_pct = 0;
  suppression_scoreboard sb;

  greedy_box_suppression uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_box_left     (in_box_left),
    .in_box_top      (in_box_top),
    .in_box_width    (in_box_width),
    .in_box_height   (in_box_height),
    .in_first_of_set (in_first_of_set),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_box_index   (out_box_index),
    .out_kept        (out_kept),
    .out_overflow    (out_overflow)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // result transfer check and random receiver stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_verdict(out_box_index, out_kept, out_overflow);
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic send_box(input logic signed [15:0] left, input logic signed [15:0] top,
                          input logic [14:0] width, input logic [14:0] height,
                          input logic first);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_box_left <= left;
    in_box_top <= top;
    in_box_width <= width;
    in_box_height <= height;
    in_first_of_set <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.predict_box(left, top, width, height, first);
  endtask

  // hold off the sender until every predicted result has come back
  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_limit(value);
  endtask

  task automatic run_random_phase(input int idle_pct, input int hold_pct,
                                  input logic [15:0] limit, input int items);
    int sent, n_boxes, n_obj, k, sw, sh, mode, l, t, w, h;
    int obj_l[4], obj_t[4], obj_w[4], obj_h[4];
    send_idle_pct = idle_pct;
    stall_pct = hold_pct;
    wait_idle(4);
    write_limit(limit);
    sent = 0;
    while (sent < items) begin
      n_boxes = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                             : $urandom_range(1, 24);
      if (n_boxes > items - sent) n_boxes = items - sent;
      n_obj = $urandom_range(1, 4);
      // a few objects per set, each seen as a cluster of jittered boxes
      for (int o = 0; o < n_obj; o++) begin
        if ($urandom_range(0, 3) == 0) begin
          obj_l[o] = $urandom_range(0, 65535) - 32768;
          obj_t[o] = $urandom_range(0, 65535) - 32768;
          obj_w[o] = $urandom_range(0, 32767);
          obj_h[o] = $urandom_range(0, 32767);
        end else begin
          obj_l[o] = $urandom_range(0, 60000) - 30000;
          obj_t[o] = $urandom_range(0, 60000) - 30000;
          obj_w[o] = $urandom_range(16, 800);
          obj_h[o] = $urandom_range(16, 800);
        end
      end
      for (int i = 0; i < n_boxes; i++) begin
        k = $urandom_range(0, n_obj - 1);
        mode = $urandom_range(0, 19);
        sw = obj_w[k] / 3 + 1;
        sh = obj_h[k] / 3 + 1;
        l = obj_l[k] + $urandom_range(0, 2 * sw) - sw;
        t = obj_t[k] + $urandom_range(0, 2 * sh) - sh;
        w = obj_w[k] + $urandom_range(0, sw) - sw / 2;
        h = obj_h[k] + $urandom_range(0, sh) - sh / 2;
        if (w < 0) w = 0;
        if (h < 0) h = 0;
        if (w > 32767) w = 32767;
        if (h > 32767) h = 32767;
        if (mode == 0) begin
          l = $urandom_range(0, 65535) - 32768;
          t = $urandom_range(0, 65535) - 32768;
          w = $urandom_range(0, 32767);
          h = $urandom_range(0, 32767);
        end else if (mode == 1) begin
          if ($urandom_range(0, 1) == 1) w = 0;
          else h = 0;
        end
        send_box(16'(l), 16'(t), 15'(w), 15'(h), (i == 0) || ($urandom_range(0, 49) == 0));
      end
      sent += n_boxes;
      if ($urandom_range(0, 7) == 0) begin
        wait_idle(4);
        write_limit(16'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("FAIL greedy_box_suppression");
    $finish;
  end

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit of one half
    send_box(16'sd0, 16'sd0, 15'd256, 15'd256, 1'b1);
    send_box(16'sd0, 16'sd0, 15'd256, 15'd256, 1'b0);
    send_box(16'sd128, 16'sd0, 15'd256, 15'd256, 1'b0);
    send_box(16'sd256, 16'sd0, 15'd256, 15'd256, 1'b0);
    // zero-area boxes, zero union between them
    send_box(16'sd64, 16'sd64, 15'd0, 15'd200, 1'b0);
    send_box(16'sd64, 16'sd64, 15'd0, 15'd200, 1'b0);
    // coordinate and size extremes
    send_box(-16'sd32768, -16'sd32768, 15'h7fff, 15'h7fff, 1'b0);
    send_box(-16'sd32768, -16'sd32768, 15'h7fff, 15'h7ffe, 1'b0);
    send_box(16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff, 1'b0);
    send_box(16'sh5555, -16'sh5556, 15'h2aaa, 15'h5555, 1'b0);
    send_box(-16'sh5556, 16'sh5555, 15'h5555, 15'h2aaa, 1'b0);
    // set restarts, back to back
    send_box(16'sd0, 16'sd0, 15'd256, 15'd256, 1'b1);
    send_box(16'sd0, 16'sd0, 15'd256, 15'd256, 1'b1);
    send_box(16'sd10, 16'sd10, 15'd256, 15'd256, 1'b0);

    // zero limit drops any overlap, touching corners survive
    wait_idle(4);
    write_limit(16'h0000);
    send_box(16'sd0, 16'sd0, 15'd256, 15'd256, 1'b1);
    send_box(16'sd255, 16'sd255, 15'd256, 15'd256, 1'b0);
    send_box(16'sd256, 16'sd256, 15'd10, 15'd10, 1'b0);

    // top limit still drops exact copies
    wait_idle(4);
    write_limit(16'hffff);
    send_box(16'sd0, 16'sd0, 15'd256, 15'd256, 1'b1);
    send_box(16'sd0, 16'sd0, 15'd256, 15'd256, 1'b0);
    send_box(16'sd0, 16'sd0, 15'd256, 15'd255, 1'b0);

    run_random_phase(0, 0, 16'hffff, 140);
    run_random_phase(80, 0, 16'h0000, 140);
    run_random_phase(0, 80, 16'($urandom_range(0, 65535)), 140);
    run_random_phase(15, 15, 16'h4ccd, 140);

    wait_idle(1100);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS greedy_box_suppression");
    end else begin
      $display("FAIL greedy_box_suppression");
    end
    $finish;
  end

endmodule
